FILE: sv/fpba_pkg.sv
// fpba_pkg: shared types and constants for the fit-policy block allocator
// holds the policy codes, config register indexes and stream field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

   // allocation policy register codes
   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_NEXT  = 2'd2,
      POL_WORST = 2'd3
   } policy_type;

   // config register indexes
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 1'd1;

   // block_count register reset value
   localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

   // input item kinds
   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_REQUEST = 1'b1;

   // stream field widths
   localparam int INDEX_W  = 4;
   localparam int AMOUNT_W = 16;
   localparam int TDATA_W  = 24;

endpackage : fpba_pkg

`default_nettype wire

FILE: sv/fit_policy_block_allocator.sv
// fit_policy_block_allocator: block allocator with first, best, next and worst fit
// a load item is written to the table in idle; a request runs setup, then a scan of the m blocks
// in use that reads one capacity per cycle from the table (none when m = 0), then finishes;
// first and next fit stop at the first fitting block; a result not yet taken holds the next
// request in its last cycle; reset: policy = first fit, block_count = 16, rover = 0, table
// not cleared and holds garbage until loaded
`timescale 1ns / 1ps
`default_nettype none

module fit_policy_block_allocator
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   // request stream
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [TDATA_W-1:0]    req_tdata,   // block_index[3:0], amount[19:4], zeros
   input  wire                   req_tuser,   // mode
   input  wire                   req_tlast,   // final_request
   // response stream
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [TDATA_W-1:0]    rsp_tdata,   // block_number[3:0], remaining[19:4], zeros
   output logic                  rsp_tuser,   // granted
   // config write channel
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int IW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   policy_type           policy_ff, policy_in;
   logic [4:0]           block_count_ff, block_count_in;
   logic [IDX_W-1:0]     rover_ff, rover_in;
   logic [IDX_W-1:0]     start_ff, start_in;
   logic [IDX_W-1:0]     iss_ff, iss_in;
   logic [IDX_W-1:0]     ev_addr_ff, ev_addr_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [CNT_W-1:0]     step_ff, step_in;
   logic [CNT_W-1:0]     m_ff, m_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [SIZE_BITS-1:0] cap_ff, cap_in;
   logic                 found_ff, found_in;
   logic                 final_ff, final_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic [INDEX_W-1:0]   rsp_block_ff, rsp_block_in;
   logic [AMOUNT_W-1:0]  rsp_rem_ff, rsp_rem_in;

   // request field unpacking
   logic                 in_mode;
   logic [INDEX_W-1:0]   in_index;
   logic [AMOUNT_W-1:0]  in_amount;
   logic [IW-1:0]        in_index_ext;
   logic [9:0]           bc_ext;
   logic [CNT_W-1:0]     m_now;
   logic [IDX_W-1:0]     start_now;
   logic [CNT_W-1:0]     iss_plus;
   logic                 req_acc;
   logic                 rsp_free;
   logic                 fits;

   // table ports
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic [SIZE_BITS-1:0] rd_data;
   logic [SIZE_BITS-1:0] cap_left;
   logic [IW-1:0]        pick_ext;

   assign in_mode      = req_tuser;
   assign in_index     = req_tdata[INDEX_W-1:0];
   assign in_amount    = req_tdata[INDEX_W +: AMOUNT_W];
   assign in_index_ext = IW'(in_index);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // blocks in use, saturated to the table depth
   assign bc_ext    = 10'(block_count_ff);
   assign m_now     = (bc_ext > 10'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(block_count_ff);
   // only next fit starts at the rover, the other policies scan from block 0
   assign start_now = (policy_ff == POL_NEXT && CNT_W'(rover_ff) < m_now) ? rover_ff : '0;

   // circular advance of the issue address
   assign iss_plus = CNT_W'(iss_ff) + CNT_W'(1);
   assign fits     = (rd_data >= size_ff);
   assign cap_left = cap_ff - size_ff;
   assign pick_ext = IW'(pick_ff);

   fpba_ram #(
      .WIDTH(SIZE_BITS),
      .DEPTH(NUM_BLOCKS)
   ) u_cap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (iss_ff),
      .rd_data (rd_data)
   );

   // config registers
   always_comb begin
      policy_in      = policy_ff;
      block_count_in = block_count_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POLICY:      policy_in      = policy_type'(csr_data[1:0]);
            CSR_BLOCK_COUNT: block_count_in = csr_data;
            default:         ;
         endcase
      end
   end

   // table write: loads in idle, capacity update when a request finishes
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pick_ff;
      wr_data = cap_left;
      if (state_ff == ST_IDLE) begin
         wr_addr = in_index_ext[IDX_W-1:0];
         wr_data = SIZE_BITS'(in_amount);
         wr_en   = req_acc && (in_mode == MODE_LOAD) && ((IW + 1)'(in_index) <
                   (IW + 1)'(NUM_BLOCKS));
      end else if (state_ff == ST_FINISH) begin
         wr_en = rsp_free && found_ff;
      end
   end

   // sequencer: setup, scan one block per cycle, then update and respond
   always_comb begin
      state_in       = state_ff;
      rover_in       = rover_ff;
      start_in       = start_ff;
      iss_in         = iss_ff;
      ev_addr_in     = iss_ff;
      pick_in        = pick_ff;
      step_in        = step_ff;
      m_in           = m_ff;
      size_in        = size_ff;
      cap_in         = cap_ff;
      found_in       = found_ff;
      final_in       = final_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_granted_in = rsp_granted_ff;
      rsp_block_in   = rsp_block_ff;
      rsp_rem_in     = rsp_rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (in_mode == MODE_LOAD) begin
                  rover_in = '0;
               end else begin
                  size_in  = SIZE_BITS'(in_amount);
                  final_in = req_tlast;
                  m_in     = m_now;
                  start_in = start_now;
                  iss_in   = start_now;
                  step_in  = '0;
                  found_in = 1'b0;
                  state_in = (m_now == '0) ? ST_FINISH : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue the next read
            if (step_ff < m_ff) begin
               iss_in = (iss_plus == m_ff) ? '0 : iss_ff + IDX_W'(1);
            end
            step_in = step_ff + CNT_W'(1);
            // evaluate the capacity read in the previous cycle
            if (step_ff != '0 && fits) begin
               case (policy_ff)
                  POL_FIRST, POL_NEXT: begin
                     found_in = 1'b1;
                     pick_in  = ev_addr_ff;
                     cap_in   = rd_data;
                     state_in = ST_FINISH;
                  end
                  POL_BEST: begin
                     if (!found_ff || rd_data < cap_ff) begin
                        found_in = 1'b1;
                        pick_in  = ev_addr_ff;
                        cap_in   = rd_data;
                     end
                  end
                  POL_WORST: begin
                     if (!found_ff || rd_data > cap_ff) begin
                        found_in = 1'b1;
                        pick_in  = ev_addr_ff;
                        cap_in   = rd_data;
                     end
                  end
                  default: ;
               endcase
            end
            if (step_ff == m_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = found_ff;
               rsp_block_in   = found_ff ? pick_ext[INDEX_W-1:0] : '0;
               rsp_rem_in     = found_ff ? AMOUNT_W'(cap_left) : '0;
               if (policy_ff == POL_NEXT && m_ff != '0) begin
                  rover_in = found_ff ? pick_ff : start_ff;
               end
               if (final_ff) begin
                  rover_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         policy_ff      <= POL_FIRST;
         block_count_ff <= BLOCK_COUNT_RST;
         rover_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
         found_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         policy_ff      <= policy_in;
         block_count_ff <= block_count_in;
         rover_ff       <= rover_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
         found_ff       <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      start_ff       <= start_in;
      iss_ff         <= iss_in;
      ev_addr_ff     <= ev_addr_in;
      pick_ff        <= pick_in;
      m_ff           <= m_in;
      size_ff        <= size_in;
      cap_ff         <= cap_in;
      final_ff       <= final_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_block_ff   <= rsp_block_in;
      rsp_rem_ff     <= rsp_rem_in;
   end

   // response packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {(TDATA_W - INDEX_W - AMOUNT_W)'(0), rsp_rem_ff, rsp_block_ff};

   // scan step never runs past the blocks in use
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff <= m_ff))
      else $error("scan step past block count");

   // issue address stays inside the blocks in use while scanning
   a_iss_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CNT_W'(iss_ff) < m_ff))
      else $error("scan address out of range");

   // an accepted request always leaves idle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      (req_acc && in_mode == MODE_REQUEST) |=> (state_ff != ST_IDLE))
      else $error("request did not start");

   // refused requests report zero block and capacity
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |-> (rsp_block_ff == '0 && rsp_rem_ff == '0))
      else $error("refused item carries nonzero payload");

endmodule : fit_policy_block_allocator

`default_nettype wire

FILE: sv/fpba_ram.sv
// fpba_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fpba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire                           clock,
   input  wire                           wr_en,
   input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]              wr_data,
   input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : fpba_ram

`default_nettype wire

FILE: bench/fpba_checker.sv
`timescale 1ns / 1ps
// fpba_checker: result checker for the fit-policy block allocator
// mirrors the capacity table, policy, block count and next-fit pointer from observed items
// depends on fpba_pkg for policy codes, register indexes, item kinds and field widths

module fpba_checker
   import fpba_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // request stream, watched only
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   input  wire  [TDATA_W-1:0]    req_tdata,   // block_index[3:0], amount[19:4], zeros
   input  wire                   req_tuser,   // mode
   input  wire                   req_tlast,   // final_request
   // response stream, watched only
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire  [TDATA_W-1:0]    rsp_tdata,   // block_number[3:0], remaining[19:4], zeros
   input  wire                   rsp_tuser,   // granted
   // config write channel, watched only
   input  wire                   csr_valid,
   input  wire                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   // status for the bench top
   output int                    fail_count,
   output int                    pending
);

   localparam int NUM_BLOCKS  = 16;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                granted;
      logic [INDEX_W-1:0]  block_number;
      logic [AMOUNT_W-1:0] remaining;
   } alloc_grant_type;

   // mirrored allocator state
   logic [AMOUNT_W-1:0] free_cap [NUM_BLOCKS];
   policy_type          fit_policy;
   logic [4:0]          blocks_cfg;
   int                  next_fit_ptr;
   alloc_grant_type     grants_due [$];

   // pick a block for one request under the current policy and charge it
   task automatic serve_request(input logic [AMOUNT_W-1:0] size, input logic final_flag,
                                output alloc_grant_type grant);
      int m;
      int k;
      int j;
      int pick;
      bit found;
      m     = (blocks_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_cfg);
      found = 1'b0;
      pick  = 0;
      if (m != 0) begin
         if (fit_policy == POL_NEXT) begin
            // circular scan from the pointer; a full failed lap ends where it began
            k = (next_fit_ptr < m) ? next_fit_ptr : 0;
            for (j = 0; j < m && !found; j++) begin
               if (free_cap[k] >= size) begin
                  found = 1'b1;
                  pick  = k;
               end else begin
                  k = (k + 1 == m) ? 0 : k + 1;
               end
            end
            next_fit_ptr = k;
         end else begin
            // linear scan, ties keep the lower index
            for (j = 0; j < m && !(found && fit_policy == POL_FIRST); j++) begin
               if (free_cap[j] >= size) begin
                  if (!found ||
                      (fit_policy == POL_BEST  && free_cap[j] < free_cap[pick]) ||
                      (fit_policy == POL_WORST && free_cap[j] > free_cap[pick])) begin
                     pick  = j;
                     found = 1'b1;
                  end
               end
            end
         end
      end
      if (found) begin
         free_cap[pick] = free_cap[pick] - size;
         grant = '{1'b1, INDEX_W'(pick), free_cap[pick]};
      end else begin
         grant = '0;
      end
      if (final_flag)
         next_fit_ptr = 0;
   endtask

   // results are handled before new requests; a result never answers a same-cycle item
   always @(posedge clock) begin
      alloc_grant_type seen;
      alloc_grant_type want;
      alloc_grant_type made;
      if (reset) begin
         for (int i = 0; i < NUM_BLOCKS; i++)
            free_cap[i] = '0;
         fit_policy   = POL_FIRST;
         blocks_cfg   = BLOCK_COUNT_RST;
         next_fit_ptr = 0;
         fail_count   = 0;
         grants_due.delete();
      end else begin
         // compare each result with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tuser, rsp_tdata[INDEX_W-1:0], rsp_tdata[INDEX_W +: AMOUNT_W]};
            if (grants_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("[%0t] unexpected result item: granted=%0b block=%0d remaining=%0d",
                           $realtime, seen.granted, seen.block_number, seen.remaining);
            end else begin
               want = grants_due.pop_front();
               if (seen.granted !== want.granted || seen.block_number !== want.block_number ||
                   seen.remaining !== want.remaining) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display({"[%0t] result mismatch: expected granted=%0b block=%0d ",
                               "remaining=%0d, got granted=%0b block=%0d remaining=%0d"},
                              $realtime, want.granted, want.block_number, want.remaining,
                              seen.granted, seen.block_number, seen.remaining);
               end
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POLICY)
               fit_policy = policy_type'(csr_data[1:0]);
            else if (csr_index == CSR_BLOCK_COUNT)
               blocks_cfg = csr_data;
         end
         // loads update the table, requests produce one expected result
         if (req_tvalid && req_tready) begin
            if (req_tuser == MODE_LOAD) begin
               free_cap[req_tdata[INDEX_W-1:0]] = req_tdata[INDEX_W +: AMOUNT_W];
               next_fit_ptr = 0;
            end else begin
               serve_request(req_tdata[INDEX_W +: AMOUNT_W], req_tlast, made);
               grants_due.push_back(made);
            end
         end
      end
      pending = grants_due.size();
   end

endmodule : fpba_checker

FILE: bench/fit_policy_block_allocator_tb.sv
`timescale 1ns / 1ps
// fit_policy_block_allocator_tb: bench top for the fit-policy block allocator
// drives directed then random load and request items with bursty sender and stalling receiver
// depends on fpba_pkg, fit_policy_block_allocator and fpba_checker

module fit_policy_block_allocator_tb;
   import fpba_pkg::*;

   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int SETTLE_CYCLES   = 40;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_BURSTY
   } ready_pattern_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata;   // block_index[3:0], amount[19:4], zeros
   logic                  req_tuser;   // mode
   logic                  req_tlast;   // final_request
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [TDATA_W-1:0]    rsp_tdata;   // block_number[3:0], remaining[19:4], zeros
   logic                  rsp_tuser;   // granted
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    fail_count;
   int                    pending;

   int                    burst_left;
   logic [AMOUNT_W-1:0]   loaded_cap [16];

   fit_policy_block_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   fpba_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #1_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // receiver stalls, pattern picked anew every segment
   initial begin
      int                seg_left;
      int                hold;
      ready_pattern_type pattern;
      rsp_tready = 1'b0;
      seg_left   = 0;
      hold       = 0;
      pattern    = RDY_ALWAYS;
      forever begin
         @(negedge clock);
         if (seg_left == 0) begin
            seg_left = $urandom_range(200, 20);
            pattern  = ready_pattern_type'($urandom_range(2, 0));
         end
         seg_left--;
         case (pattern)
            RDY_ALWAYS: rsp_tready <= 1'b1;
            RDY_COIN:   rsp_tready <= 1'($urandom_range(1, 0));
            default: begin
               if (hold > 0) begin
                  hold--;
                  rsp_tready <= 1'b0;
               end else if ($urandom_range(5, 0) == 0) begin
                  hold = $urandom_range(12, 1);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // send one item, with a random gap at the start of each burst
   task automatic push_item(input logic mode, input logic [INDEX_W-1:0] idx,
                            input logic [AMOUNT_W-1:0] amt, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap        = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tlast  <= last;
      req_tdata  <= TDATA_W'({amt, idx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (mode == MODE_LOAD)
         loaded_cap[idx] = amt;
   endtask

   // stop sending, wait for all results and let the block drain
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register write, block must be idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // policy write with random don't-care upper bits
   task automatic write_policy(input policy_type pol);
      write_csr(CSR_POLICY, {3'($urandom_range(7, 0)), 2'(pol)});
   endtask

   function automatic logic [AMOUNT_W-1:0] pick_load_amount();
      int sel;
      sel = $urandom_range(9, 0);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      if (sel < 4) return AMOUNT_W'($urandom());
      return AMOUNT_W'($urandom_range(65535, 1000));
   endfunction

   // sizes lean small or relative to loaded capacity so most requests can land
   function automatic logic [AMOUNT_W-1:0] pick_request_size();
      int                  sel;
      logic [AMOUNT_W-1:0] cap;
      sel = $urandom_range(19, 0);
      cap = loaded_cap[$urandom_range(15, 0)];
      if (sel < 2) return '0;
      if (sel < 3) return '1;
      if (sel < 9) return AMOUNT_W'($urandom_range(255, 0));
      if (sel < 13) return AMOUNT_W'($urandom_range(int'(cap) / 2, 0));
      if (sel < 16) return AMOUNT_W'($urandom_range(4095, 0));
      return AMOUNT_W'($urandom());
   endfunction

   // stimulus and verdict
   initial begin
      int         phase;
      int         n;
      logic [4:0] cnt;
      policy_type pol;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_LOAD;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_index  = CSR_POLICY;
      csr_data   = '0;
      burst_left = 0;
      for (int i = 0; i < 16; i++)
         loaded_cap[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: four blocks with an empty one and a tie
      write_csr(CSR_BLOCK_COUNT, 5'd4);
      write_policy(POL_FIRST);
      push_item(MODE_LOAD, 4'd0, 16'hFFFF, 1'b1);
      push_item(MODE_LOAD, 4'd1, 16'd10, 1'b0);
      push_item(MODE_LOAD, 4'd2, 16'd0, 1'b0);
      push_item(MODE_LOAD, 4'd3, 16'd10, 1'b0);
      // first fit: zero size, normal size, too large
      push_item(MODE_REQUEST, 4'd15, 16'd0, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd11, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'hFFFF, 1'b0);
      settle();
      // best fit: tie goes to the lower block
      write_policy(POL_BEST);
      push_item(MODE_REQUEST, 4'd0, 16'd5, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd10, 1'b0);
      settle();
      // worst fit
      write_policy(POL_WORST);
      push_item(MODE_REQUEST, 4'd0, 16'd1, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd0, 1'b0);
      settle();
      // next fit: pointer moves, wraps, fails a full lap, final flag and load reset it
      write_policy(POL_NEXT);
      push_item(MODE_REQUEST, 4'd0, 16'hFFF0, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd4, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd2, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd9, 1'b0);
      push_item(MODE_REQUEST, 4'd0, 16'd1, 1'b1);
      push_item(MODE_LOAD, 4'd2, 16'd7, 1'b1);
      push_item(MODE_REQUEST, 4'd0, 16'd7, 1'b0);
      settle();
      // pointer beyond the block count restarts at block 0
      write_csr(CSR_BLOCK_COUNT, 5'd2);
      push_item(MODE_REQUEST, 4'd0, 16'd0, 1'b0);
      settle();
      // no blocks in use: even a zero size is refused
      write_csr(CSR_BLOCK_COUNT, 5'd0);
      push_item(MODE_REQUEST, 4'd0, 16'd0, 1'b0);

      // random: fill every block, then phases of settings
      for (int i = 0; i < 16; i++)
         push_item(MODE_LOAD, INDEX_W'(i), pick_load_amount(), 1'($urandom_range(1, 0)));
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle();
         pol = (phase < 8) ? policy_type'(phase % 4) : policy_type'($urandom_range(3, 0));
         case (phase)
            0: cnt = 5'd16;
            1: cnt = 5'd1;
            2: cnt = 5'd31;
            3: cnt = 5'd0;
            4: cnt = 5'd17;
            5: cnt = 5'd16;
            6: cnt = 5'd2;
            7: cnt = 5'd31;
            default: cnt = ($urandom_range(5, 0) == 0) ? 5'($urandom_range(31, 17))
                                                       : 5'($urandom_range(16, 1));
         endcase
         write_policy(pol);
         write_csr(CSR_BLOCK_COUNT, cnt);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(4, 0) == 0)
               push_item(MODE_LOAD, INDEX_W'($urandom_range(15, 0)), pick_load_amount(),
                         1'($urandom_range(1, 0)));
            else
               push_item(MODE_REQUEST, INDEX_W'($urandom_range(15, 0)), pick_request_size(),
                         ($urandom_range(7, 0) == 0));
         end
      end

      settle();
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule : fit_policy_block_allocator_tb
